FILE: rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes of the sorted priority queue
// Operation and status codes, beat layout, controller states and the command
// bundle from controller to datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int PRIO_W    = 32;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;

	// input beat: operation, priority_req, zero fill to 40 bits
	localparam int IN_W  = 40;
	// output beat: status, head_value, entry_count, zero fill to 40 bits
	localparam int OUT_W = 40;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_POP    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;     // capture the input beat
		logic compare;  // register per-cell compare flags
		logic commit;   // apply the update and load the result register
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl - sequencer of the sorted priority queue
// Walks each beat through capture, compare and commit, and owns the
// handshake of both channels, including the output valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output spq_pkg::cmd_t     cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_d;
	logic            out_vld_q;
	logic            slot_free;

	assign slot_free = !out_vld_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = spq_pkg::ST_CMP;
			end
			spq_pkg::ST_CMP: begin
				state_d = spq_pkg::ST_UPD;
			end
			spq_pkg::ST_UPD: begin
				if (slot_free) state_d = spq_pkg::ST_IDLE;
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.compare = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			spq_pkg::ST_CMP: begin
				cmd.compare = 1'b1;
			end
			spq_pkg::ST_UPD: begin
				cmd.commit = slot_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spq_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;

`ifndef SYNTH
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("result not presented after commit");
	a_cmp_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |-> $past(cmd.load))
		else $error("compare without a captured beat");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.commit)
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/spq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath - row of sorted compare cells
// Each cell holds one priority and compares it with the request; the
// registered flags then drive a one-step shift right (insert) or left
// (remove, pop) of the row. Also holds the fill count and result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire spq_pkg::cmd_t                cmd,
	input  wire logic [spq_pkg::IN_W-1:0]     in_data,
	output logic      [spq_pkg::OUT_W-1:0]    res_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [spq_pkg::OP_W-1:0]          op_q;
	logic signed [spq_pkg::PRIO_W-1:0] req_q;
	logic signed [spq_pkg::PRIO_W-1:0] ent_q [DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] ent_d [DEPTH];
	logic [CW-1:0]                     cnt_q;
	logic [CW-1:0]                     cnt_d;
	logic [DEPTH-1:0]                  ge_q;   // valid and entry <= request
	logic [DEPTH-1:0]                  eq_q;   // valid and entry == request
	logic [DEPTH-1:0]                  vld_q;  // cell below fill count
	logic [DEPTH-1:0]                  take;
	logic [DEPTH-1:0]                  shr;
	logic [DEPTH-1:0]                  shl;
	logic                              found;
	logic                              full;
	logic                              empty;
	logic                              ins_ok;
	logic                              rem_ok;
	logic                              pop_ok;
	logic [spq_pkg::STAT_W-1:0]        stat_d;
	logic signed [spq_pkg::PRIO_W-1:0] head_d;
	logic [CW+spq_pkg::CNT_OUT_W-1:0]  cnt_wide;
	logic [spq_pkg::OUT_W-1:0]         res_q;

	assign found  = |eq_q;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign ins_ok = (op_q == spq_pkg::OP_INSERT) && !full;
	assign rem_ok = (op_q == spq_pkg::OP_REMOVE) && found;
	assign pop_ok = (op_q == spq_pkg::OP_POP) && !empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic vld_i;
		assign vld_i = (CW'(i) < cnt_q);

		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				vld_q[i] <= vld_i;
				ge_q[i]  <= vld_i && (ent_q[i] <= req_q);
				eq_q[i]  <= vld_i && (ent_q[i] == req_q);
			end
		end

		// insert slot: first cell at or past the boundary, after a cell that stays
		if (i == 0) begin : g_head
			assign take[i] = ge_q[i] || !vld_q[i];
			assign shr[i]  = 1'b0;
		end else begin : g_body
			assign take[i] = (ge_q[i] || !vld_q[i]) && vld_q[i-1] && !ge_q[i-1];
			assign shr[i]  = ge_q[i-1] || !vld_q[i-1];
		end

		// sorted row: cells from the first match onward all have entry <= request
		assign shl[i] = (rem_ok && ge_q[i]) || pop_ok;

		if (i < DEPTH - 1) begin : g_next
			always_comb begin
				if (ins_ok) begin
					if (take[i]) ent_d[i] = req_q;
					else if (shr[i]) ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
					else ent_d[i] = ent_q[i];
				end else if (shl[i]) begin
					ent_d[i] = ent_q[i+1];
				end else begin
					ent_d[i] = ent_q[i];
				end
			end
		end else begin : g_last
			always_comb begin
				if (ins_ok && take[i]) ent_d[i] = req_q;
				else if (ins_ok && shr[i]) ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
				else ent_d[i] = ent_q[i];
			end
		end
	end

	always_comb begin
		if (ins_ok) cnt_d = cnt_q + CW'(1);
		else if (rem_ok || pop_ok) cnt_d = cnt_q - CW'(1);
		else cnt_d = cnt_q;
	end

	always_comb begin
		case (op_q)
			spq_pkg::OP_INSERT: stat_d = full ? spq_pkg::STAT_FULL : spq_pkg::STAT_OK;
			spq_pkg::OP_REMOVE: stat_d = found ? spq_pkg::STAT_OK : spq_pkg::STAT_NOT_FOUND;
			spq_pkg::OP_POP:    stat_d = empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
			default:            stat_d = spq_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		if (op_q == spq_pkg::OP_POP) head_d = empty ? '0 : ent_q[0];
		else head_d = (cnt_d != '0) ? ent_d[0] : '0;
	end

	assign cnt_wide = (CW + spq_pkg::CNT_OUT_W)'(cnt_d);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data[spq_pkg::OP_W-1:0];
			req_q <= in_data[spq_pkg::OP_W +: spq_pkg::PRIO_W];
		end
		if (cmd.commit) begin
			ent_q <= ent_d;
			res_q <= {1'b0, cnt_wide[spq_pkg::CNT_OUT_W-1:0], head_d, stat_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			cnt_q <= cnt_d;
		end
	end

	assign res_data = res_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count above depth");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == spq_pkg::OP_INSERT) && full) |=> $stable(cnt_q))
		else $error("insert into full queue changed count");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && pop_ok) |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("pop did not drop one entry");
`endif

endmodule
`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded priority queue kept sorted high to low
// Up to QUEUE_DEPTH signed 32-bit priorities in a row of compare cells.
// Input beat (s_*): operation (0 insert, 1 remove first equal, 2 pop head)
// and priority_req. Output beat (m_*): status (0 ok, 1 full, 2 not found,
// 3 empty), head_value (popped value on pop, else head after the operation,
// 0 when empty) and entry_count. Equal priorities pop last in, first out.
// Each beat makes exactly one result beat.
// Sequence: an accepted beat is captured, its compare flags are registered,
// then it is committed, a step that waits for a free result register;
// its result is valid from then on. Accepting holds off for the whole
// capture, compare, commit walk of the controller around the cell row.
// The result sits in an output register: the next beat is accepted while it
// waits. If the receiver stalls, the following beat waits in the commit step
// until the result register frees, and s_tready stays low meanwhile.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending
// result; stored entries are not cleared, the fill count masks them.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [1:0] operation, [33:2] priority_req, [39:34] zero
	input  wire logic [spq_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [1:0] status, [33:2] head_value, [38:34] entry_count, [39] zero
	output logic      [spq_pkg::OUT_W-1:0]  m_tdata
);

	spq_pkg::cmd_t cmd;

	// sequencer: handshake and step commands
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// cell row, fill count and result register
	spq_datapath #(
		.DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.res_data (m_tdata)
	);

endmodule
`default_nettype wire
